### src/kmp_pkg.sv
package kmp_pkg;

    localparam int MAX_PATTERN_DEF = 256;
    localparam int SYMBOL_BITS_DEF = 8;
    localparam int OPCODE_W        = 2;
    localparam int IN_SYM_W        = 8;
    localparam int POS_W           = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_TEXT    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_STEP = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch the input beat, start the first read
        logic advance;  // follow one failure link
        logic commit;   // apply the result and load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;     // current item has its final prefix length
    } t_status;

endpackage

### src/kmp_ctrl.sv
module kmp_ctrl
    import kmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output logic    o_ready,
    output logic    o_valid,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_STEP;
            end
            ST_STEP: begin
                if (i_status.done && slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        o_cmd          = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_STEP: begin
                o_cmd.advance = !i_status.done;
                o_cmd.commit  = i_status.done && slot_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_ready) n_out_valid = 1'b0;
        if (o_cmd.commit) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### src/kmp_dp.sv
module kmp_dp
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [IN_SYM_W-1:0] i_symbol,
    output t_status             o_status,
    output logic                o_match_found,
    output logic [POS_W-1:0]    o_match_start,
    output logic                o_pattern_full
);

    localparam int LW = $clog2(MAX_PATTERN + 1);  // lengths 0..MAX_PATTERN
    localparam int AW = $clog2(MAX_PATTERN);      // store index
    localparam int SW = SYMBOL_BITS;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);
    localparam logic [LW-1:0] LEN_ONE = LW'(1);

    // pattern symbols and failure links
    logic [SW-1:0] r_pstore [MAX_PATTERN];
    logic [LW-1:0] r_ftab   [MAX_PATTERN];
    logic [SW-1:0] r_rd_sym;
    logic [LW-1:0] r_rd_fail;

    t_op             r_op;
    logic [SW-1:0]   r_sym;
    logic [LW-1:0]   r_k, n_k;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_bk, n_bk;
    logic [LW-1:0]   r_mk, n_mk;
    logic [POS_W-1:0] r_pos, n_pos;
    logic            r_found, n_found;
    logic [POS_W-1:0] r_start, n_start;
    logic            r_full, n_full;

    logic [SW+IN_SYM_W-1:0] sym_wide;
    logic [SW-1:0]   sym_in;
    logic [LW-1:0]   k0, rd_addr, rd_addr_m1, kf;
    logic            is_loop, eq, kz, len_zero, len_full, wr_en;
    logic [POS_W-1:0] pos_inc;

    // symbol field narrowed or widened to the store width
    assign sym_wide = {{SW{1'b0}}, i_symbol};
    assign sym_in   = sym_wide[SW-1:0];

    assign len_zero = (r_len == '0);
    assign len_full = (r_len == LEN_MAX);

    // starting prefix length for the item being accepted
    always_comb begin
        if (t_op'(i_opcode) == OP_APPEND) k0 = r_bk;
        else if (r_mk > r_len)            k0 = '0;
        else                              k0 = r_mk;
    end

    always_comb begin
        if (i_cmd.accept)       rd_addr = k0;
        else if (i_cmd.advance) rd_addr = r_rd_fail;
        else                    rd_addr = r_k;
    end
    assign rd_addr_m1 = rd_addr - LEN_ONE;

    // one compare per cycle in the step state
    assign is_loop = !len_zero &&
                     ((r_op == OP_TEXT) || ((r_op == OP_APPEND) && !len_full));
    assign kz      = (r_k == '0);
    assign eq      = (r_k < r_len) && (r_rd_sym == r_sym);
    assign kf      = eq ? (r_k + LEN_ONE) : r_k;
    assign o_status.done = !is_loop || kz || eq;

    assign wr_en   = i_cmd.commit && (r_op == OP_APPEND) && !len_full;
    assign pos_inc = r_pos + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) r_pstore[r_len[AW-1:0]] <= r_sym;
        r_rd_sym <= r_pstore[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_ftab[r_len[AW-1:0]] <= kf;
        r_rd_fail <= r_ftab[rd_addr_m1[AW-1:0]];
    end

    always_comb begin
        n_k     = r_k;
        n_len   = r_len;
        n_bk    = r_bk;
        n_mk    = r_mk;
        n_pos   = r_pos;
        n_found = r_found;
        n_start = r_start;
        n_full  = r_full;
        if (i_cmd.accept)  n_k = k0;
        if (i_cmd.advance) n_k = r_rd_fail;
        if (i_cmd.commit) begin
            n_found = 1'b0;
            n_start = '0;
            n_full  = 1'b0;
            case (r_op)
                OP_CLEAR: begin
                    n_len = '0;
                    n_bk  = '0;
                    n_mk  = '0;
                    n_pos = '0;
                end
                OP_APPEND: begin
                    if (len_full) begin
                        n_full = 1'b1;
                    end else begin
                        n_bk  = kf;
                        n_len = r_len + LEN_ONE;
                    end
                end
                OP_TEXT: begin
                    n_pos = pos_inc;
                    if (!len_zero) begin
                        n_mk = kf;
                        if (kf == r_len) begin
                            n_found = 1'b1;
                            n_start = pos_inc - POS_W'(r_len) + POS_W'(1);
                        end
                    end
                end
                OP_RESTART: begin
                    n_mk  = '0;
                    n_pos = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_bk  <= '0;
            r_mk  <= '0;
            r_pos <= '0;
        end else begin
            r_len <= n_len;
            r_bk  <= n_bk;
            r_mk  <= n_mk;
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= t_op'(i_opcode);
            r_sym <= sym_in;
        end
        r_k     <= n_k;
        r_found <= n_found;
        r_start <= n_start;
        r_full  <= n_full;
    end

    assign o_match_found  = r_found;
    assign o_match_start  = r_start;
    assign o_pattern_full = r_full;

endmodule

### src/kmp_stream_matcher.sv
// Streaming Knuth-Morris-Pratt matcher.
// Input channel (i_valid / o_ready): one beat carries i_opcode and i_symbol.
//   clear wipes pattern and text state, append adds one pattern symbol and
//   extends the failure table, text advances the match, restart zeroes the
//   text position and match length but keeps the pattern.
// Output channel (o_valid / i_ready): exactly one result beat per input beat,
//   in order: o_match_found with the 1-based o_match_start, or o_pattern_full
//   when an append hits a full store. Unused fields read zero.
// Sequence: an item is accepted, then takes one compare step, plus one
//   more step per failure link followed. Links are walked one per cycle
//   through the registered read port of the failure table; total link
//   steps never exceed earlier advances.
// The next beat is taken as soon as a result moves into the output register,
// even while that result still waits for i_ready. If the output register is
// still full when the next item finishes, the item holds in its compare step
// until the receiver takes the waiting beat.
// Reset (synchronous, active low) empties the pattern, zeroes the text
// position and drops o_valid. Pattern and link memories need no clearing:
// entries are used only below the current pattern length.
module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [IN_SYM_W-1:0] i_symbol,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_match_found,
    output logic [POS_W-1:0]    o_match_start,
    output logic                o_pattern_full
);

    t_cmd    cmd;
    t_status status;

    // sequencer: idle / step, owns the output valid flag
    kmp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .o_cmd    (cmd)
    );

    // lengths, position counter, pattern and failure-link memories
    kmp_dp #(
        .MAX_PATTERN (MAX_PATTERN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_opcode),
        .i_symbol       (i_symbol),
        .o_status       (status),
        .o_match_found  (o_match_found),
        .o_match_start  (o_match_start),
        .o_pattern_full (o_pattern_full)
    );

endmodule

### src/kmp_chk.sv
module kmp_chk
    import kmp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_match_found,
    input logic [POS_W-1:0] o_match_start,
    input logic             o_pattern_full
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_match_found)
            && $stable(o_match_start) && $stable(o_pattern_full))
        else $error("output beat changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_match_found && o_pattern_full))
        else $error("match and full flagged together");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_match_found |-> o_match_start == '0)
        else $error("start position without a match");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind kmp_stream_matcher kmp_chk u_kmp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_match_found  (o_match_found),
    .o_match_start  (o_match_start),
    .o_pattern_full (o_pattern_full)
);

### bench/tb_kmp_stream_matcher.sv
module tb_kmp_stream_matcher
    import kmp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAT = MAX_PATTERN_DEF;
    localparam logic [IN_SYM_W-1:0] SYM_MASK = IN_SYM_W'((1 << SYMBOL_BITS_DEF) - 1);

    // one pending input beat
    typedef struct packed {
        t_op                 op;
        logic [IN_SYM_W-1:0] sym;
    } t_kmp_item;

    // one result beat as the matcher should produce it
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
        logic             full;
    } t_match_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [OPCODE_W-1:0] i_opcode = OP_CLEAR;
    logic [IN_SYM_W-1:0] i_symbol = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_match_found;
    logic [POS_W-1:0]    o_match_start;
    logic                o_pattern_full;

    kmp_stream_matcher u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_symbol       (i_symbol),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_match_found  (o_match_found),
        .o_match_start  (o_match_start),
        .o_pattern_full (o_pattern_full)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Matcher state mirror. Pattern symbols and failure links are only
    // used below the current pattern length, same as the hardware.
    // ------------------------------------------------------------------
    logic [IN_SYM_W-1:0] pat_syms [MAX_PAT];
    int unsigned         fail_links [MAX_PAT];
    int unsigned         pat_len = 0;
    int unsigned         build_len = 0;   // prefix length reached by last append
    int unsigned         match_len = 0;   // text characters currently matched
    logic [POS_W-1:0]    text_pos = '0;

    t_kmp_item   pending_beats [$];
    t_match_beat expected_beats [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int beats_queued = 0;
    int beats_seen = 0;
    int err_count = 0;

    // stimulus alphabet of the current random episode
    logic [IN_SYM_W-1:0] stim_alpha [3] = '{default: '0};
    int                  stim_nalpha = 2;

    // Advance the mirrored state by one input beat and return the result
    // beat the matcher owes for it.
    function automatic t_match_beat kmp_predict(t_op op, logic [IN_SYM_W-1:0] raw_sym);
        t_match_beat         res;
        logic [IN_SYM_W-1:0] s;
        int unsigned         k;
        res = '0;
        s = raw_sym & SYM_MASK;
        case (op)
            OP_CLEAR: begin
                pat_len = 0;
                build_len = 0;
                match_len = 0;
                text_pos = '0;
            end
            OP_APPEND: begin
                if (pat_len >= MAX_PAT) begin
                    res.full = 1'b1;
                end else begin
                    pat_syms[pat_len] = s;
                    k = build_len;
                    if (pat_len == 0) begin
                        k = 0;
                    end else begin
                        while (k != 0 && pat_syms[k] != s) k = fail_links[k-1];
                        if (pat_syms[k] == s) k++;
                    end
                    fail_links[pat_len] = k;
                    build_len = k;
                    pat_len++;
                end
            end
            OP_TEXT: begin
                text_pos = text_pos + 1'b1;
                if (pat_len != 0) begin
                    k = match_len;
                    if (k > pat_len) k = 0;
                    // a full match falls back first, whatever the symbol
                    while (k != 0 && (k == pat_len || pat_syms[k] != s))
                        k = fail_links[k-1];
                    if (k < pat_len && pat_syms[k] == s) k++;
                    match_len = k;
                    if (k == pat_len) begin
                        res.found = 1'b1;
                        res.start = text_pos - POS_W'(pat_len) + 1'b1;
                    end
                end
            end
            default: begin  // OP_RESTART keeps the pattern
                match_len = 0;
                text_pos = '0;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [POS_W-1:0] got,
                                   input logic [POS_W-1:0] want);
        $display("MISMATCH result beat %0d: %s got 0x%0h want 0x%0h",
                 beats_seen, what, got, want);
        err_count++;
    endtask

    task automatic queue_beat(input t_op op, input logic [IN_SYM_W-1:0] sym);
        pending_beats.push_back('{op: op, sym: sym});
        beats_queued++;
    endtask

    function automatic logic [IN_SYM_W-1:0] pick_alpha();
        return stim_alpha[$urandom_range(stim_nalpha - 1)];
    endfunction

    // Mostly well-formed episodes: clear, short pattern over a tiny random
    // alphabet, then a text run from the same alphabet so matches are common.
    // Appends and restarts land inside text runs; a slice is raw noise.
    task automatic queue_random_traffic(input int count);
        int stop_at;
        int r;
        int plen;
        stop_at = beats_queued + count;
        while (beats_queued < stop_at) begin
            r = $urandom_range(99);
            if (r < 10) begin
                repeat ($urandom_range(1, 4))
                    queue_beat(t_op'($urandom_range(3)), IN_SYM_W'($urandom));
            end else begin
                if (r < 25) begin
                    queue_beat(OP_RESTART, IN_SYM_W'($urandom));
                end else begin
                    stim_nalpha = $urandom_range(2, 3);
                    foreach (stim_alpha[j]) stim_alpha[j] = IN_SYM_W'($urandom);
                    queue_beat(OP_CLEAR, IN_SYM_W'($urandom));
                    plen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
                    repeat (plen) queue_beat(OP_APPEND, pick_alpha());
                end
                repeat ($urandom_range(8, 40)) begin
                    r = $urandom_range(99);
                    if (r < 4)
                        queue_beat(OP_APPEND, pick_alpha());
                    else if (r < 7)
                        queue_beat(OP_RESTART, IN_SYM_W'($urandom));
                    else if (r < 15)
                        queue_beat(OP_TEXT, IN_SYM_W'($urandom));
                    else
                        queue_beat(OP_TEXT, pick_alpha());
                end
            end
        end
    endtask

    // Idle means: nothing left to send, nothing on the bus, nothing owed.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || i_valid || expected_beats.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver: the expectation is computed at the edge where the beat is
    // taken, then the next beat (or a gap) is offered. Valid is only
    // dropped when the current beat has gone.
    // ------------------------------------------------------------------
    t_kmp_item next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_beats.push_back(kmp_predict(t_op'(i_opcode), i_symbol));
            if (!i_valid || o_ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_beats.pop_front();
                    i_valid  <= 1'b1;
                    i_opcode <= next_item.op;
                    i_symbol <= next_item.sym;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result beat is checked against the oldest
    // expectation, field by field. Ready is re-rolled each cycle.
    // ------------------------------------------------------------------
    t_match_beat want_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat, match_start", o_match_start, '0);
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (o_match_found !== want_beat.found)
                        report_mismatch("match_found", o_match_found, want_beat.found);
                    if (o_match_start !== want_beat.start)
                        report_mismatch("match_start", o_match_start, want_beat.start);
                    if (o_pattern_full !== want_beat.full)
                        report_mismatch("pattern_full", o_pattern_full, want_beat.full);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int                  period;
        int                  idx;
        logic [IN_SYM_W-1:0] sym_a;
        logic [IN_SYM_W-1:0] period_syms [5];

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: sender mostly busy, receiver mostly stalled
        send_idle_pct = 33;
        recv_idle_pct = 76;

        // text with no pattern never matches
        queue_beat(OP_TEXT, 8'h00);
        queue_beat(OP_TEXT, 8'hFF);
        // pattern at the symbol extremes; overlapping hits exercise the
        // fall-back after a full match
        queue_beat(OP_APPEND, 8'h00);
        queue_beat(OP_APPEND, 8'hFF);
        queue_beat(OP_APPEND, 8'h00);
        queue_beat(OP_TEXT, 8'h00);
        queue_beat(OP_TEXT, 8'hFF);
        queue_beat(OP_TEXT, 8'h00);
        queue_beat(OP_TEXT, 8'hFF);
        queue_beat(OP_TEXT, 8'h00);
        // restart keeps the pattern, positions count from 1 again
        queue_beat(OP_RESTART, 8'hFF);
        queue_beat(OP_TEXT, 8'h00);
        queue_beat(OP_TEXT, 8'hFF);
        queue_beat(OP_TEXT, 8'h00);
        // grow the pattern mid-text: the matched length carries over
        queue_beat(OP_CLEAR, 8'hFF);
        queue_beat(OP_APPEND, 8'h5A);
        queue_beat(OP_TEXT, 8'h5A);
        queue_beat(OP_APPEND, 8'hA5);
        queue_beat(OP_TEXT, 8'hA5);
        // clear drops the pattern
        queue_beat(OP_CLEAR, 8'h00);
        queue_beat(OP_TEXT, 8'h5A);

        queue_random_traffic(380);
        wait_drained();  // sender holds off until every result is back

        // phase 2: roles swapped
        send_idle_pct = 76;
        recv_idle_pct = 33;
        queue_random_traffic(380);
        wait_drained();

        // phase 3: back to back, no stalls
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Fill the store with a periodic pattern, push past capacity, then
        // stream the same periodic text so the full-length pattern matches.
        period = $urandom_range(1, 5);
        sym_a = IN_SYM_W'($urandom);
        foreach (period_syms[j]) period_syms[j] = $urandom_range(1) ? sym_a : ~sym_a;
        queue_beat(OP_CLEAR, IN_SYM_W'($urandom));
        for (idx = 0; idx < MAX_PAT; idx++)
            queue_beat(OP_APPEND, period_syms[idx % period]);
        repeat (3) queue_beat(OP_APPEND, IN_SYM_W'($urandom));
        repeat (4) queue_beat(OP_TEXT, IN_SYM_W'($urandom));
        for (idx = 0; idx < MAX_PAT + 24; idx++)
            queue_beat(OP_TEXT, period_syms[idx % period]);
        queue_beat(OP_APPEND, sym_a);   // refused, the pattern store is already full
        for (; idx < MAX_PAT + 24 + 2 * period; idx++)
            queue_beat(OP_TEXT, period_syms[idx % period]);
        queue_beat(OP_CLEAR, IN_SYM_W'($urandom));

        queue_random_traffic(260);
        wait_drained();

        // let any stray beat show up before the verdict
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_kmp_stream_matcher: clean");
        else
            $display("tb_kmp_stream_matcher: errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb_kmp_stream_matcher: errors");
        $finish;
    end

endmodule

### sim.f
src/kmp_pkg.sv
src/kmp_ctrl.sv
src/kmp_dp.sv
src/kmp_stream_matcher.sv
src/kmp_chk.sv
bench/tb_kmp_stream_matcher.sv
